// ===== design/sfs_pkg.sv =====
package sfs_pkg;

	// Field widths
	localparam int unsigned FRAME_W  = 8;
	localparam int unsigned COUNT_W  = 9;
	localparam int unsigned TIME_W   = 16;
	localparam int unsigned ACC_W    = TIME_W + 1;
	localparam int unsigned DELAY_W  = TIME_W + 2;
	localparam int unsigned REP_W    = 9;
	localparam int unsigned REQ_W    = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned OUT_DATA_W = 16;

	// Largest frame count the sheet can use
	localparam logic [COUNT_W-1:0] MAX_FRAMES = COUNT_W'(256);

	// Saturation value of the time accumulators
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	// Repeat counter value meaning endless
	localparam logic signed [REP_W-1:0] REP_ENDLESS = -REP_W'(1);

	// Request kinds carried in tuser
	typedef enum logic [REQ_W-1:0] {
		REQ_TICK        = 2'd0,
		REQ_START_SHEET = 2'd1,
		REQ_START_RANGE = 2'd2,
		REQ_NONE        = 2'd3
	} req_type_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAMES_COUNT = 3'd0,
		CFG_FRAME_PERIOD = 3'd1,
		CFG_START_DELAY  = 3'd2,
		CFG_CYCLE_PAUSE  = 3'd3,
		CFG_REPEAT_COUNT = 3'd4,
		CFG_PING_PONG    = 3'd5,
		CFG_RANGE_START  = 3'd6,
		CFG_RANGE_FINISH = 3'd7
	} cfg_index_t;

	// Clamp a candidate frame to the sheet: anything at or past the limit shows frame 0
	function automatic logic [FRAME_W-1:0] show_frame(input logic [9:0] f,
		input logic [COUNT_W-1:0] lim);
		logic [FRAME_W-1:0] r;
		r = (f < {1'b0, lim}) ? f[FRAME_W-1:0] : '0;
		return r;
	endfunction

	// Saturating add of a tick delta to a time accumulator
	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
		input logic [TIME_W-1:0] delta);
		logic [ACC_W:0] sum;
		sum = {1'b0, acc} + {2'b00, delta};
		return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
	endfunction

endpackage

// ===== design/sprite_frame_sequencer_unit.sv =====
// Sprite animation frame sequencer.
// Input stream (s_*): one request per item. s_tuser holds the request kind
// (tick, start over the whole sheet, start over a frame range, anything else
// is ignored); s_tdata holds the elapsed time of a tick.
// Output stream (m_*): exactly one result per request, in order: the frame
// shown after the request, the running flag, and the end-of-cycle and
// end-of-animation pulses.
// Configuration port (cfg_*): always ready; write only while no request is
// in flight. Index selects frames_count, frame_period, start_delay,
// cycle_pause, repeat_count, ping_pong, range_start, range_finish.
// A request is accepted into the input register; the sequencing logic then
// updates the state and loads the result register, which drives m_tvalid.
// One request per cycle is sustained while the receiver keeps m_tready high;
// the only limit is that single state update, which completes in the cycle
// it is applied.
// Reset clears the animation state (frame 0, stopped, endless repeats) and
// loads the default configuration. When the receiver stalls, the result
// register holds and the input register keeps one more request; s_tready
// then drops until the result is taken.
module sprite_frame_sequencer_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [15:0] tick_delta
	input  logic [sfs_pkg::TIME_W-1:0]           s_tdata,
	// [1:0] req_type
	input  logic [sfs_pkg::REQ_W-1:0]            s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [7:0] frame_index, [8] running, [9] cycle_end, [10] anim_end, [15:11] zero
	output logic [sfs_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// Configuration registers
	logic [sfs_pkg::COUNT_W-1:0] frames_count_q;
	logic [sfs_pkg::TIME_W-1:0]  frame_period_q;
	logic [sfs_pkg::TIME_W-1:0]  start_delay_q;
	logic [sfs_pkg::TIME_W-1:0]  cycle_pause_q;
	logic [7:0]                  repeat_count_q;
	logic                        ping_pong_q;
	logic [sfs_pkg::FRAME_W-1:0] range_start_q;
	logic [sfs_pkg::FRAME_W-1:0] range_finish_q;

	// Animation state
	logic [sfs_pkg::FRAME_W-1:0]        frame_q;
	logic [sfs_pkg::ACC_W-1:0]          acc_q;
	logic signed [sfs_pkg::DELAY_W-1:0] delay_q;
	logic [sfs_pkg::ACC_W-1:0]          pause_q;
	logic signed [sfs_pkg::REP_W-1:0]   repeats_q;
	logic [7:0]                         steps_q;
	logic                               running_q;
	logic                               backward_q;
	logic                               range_mode_q;

	// Input stage and result stage
	logic                         valid_s1;
	sfs_pkg::req_type_t           req_s1;
	logic [sfs_pkg::TIME_W-1:0]   delta_s1;
	logic                         valid_s2;
	logic [sfs_pkg::OUT_DATA_W-1:0] data_s2;
	logic                         adv_s2;
	logic                         adv_s1;

	// Next-state values
	logic [sfs_pkg::FRAME_W-1:0]        n_frame;
	logic [sfs_pkg::ACC_W-1:0]          n_acc;
	logic signed [sfs_pkg::DELAY_W-1:0] n_delay;
	logic [sfs_pkg::ACC_W-1:0]          n_pause;
	logic signed [sfs_pkg::REP_W-1:0]   n_repeats;
	logic [7:0]                         n_steps;
	logic                               n_running;
	logic                               n_backward;
	logic                               n_range_mode;
	logic                               cyc;
	logic                               fin;

	// Shared terms of the step logic
	logic [sfs_pkg::COUNT_W-1:0] limit;
	logic [9:0]                  cur_plus1;
	logic [sfs_pkg::FRAME_W-1:0] fwd_frame;
	logic [sfs_pkg::FRAME_W-1:0] back_frame;
	logic                        at_last;
	logic                        rep_pos;
	logic [sfs_pkg::ACC_W-1:0]   acc_sat;
	logic [sfs_pkg::ACC_W-1:0]   pause_sat;
	logic [9:0]                  range_next;

	// Pipeline flow: result register moves when empty or taken
	assign adv_s2    = !valid_s2 || m_tready;
	assign adv_s1    = valid_s1 && adv_s2;
	assign s_tready  = !valid_s1 || adv_s2;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = data_s2;
	assign cfg_ready = 1'b1;

	// Frame arithmetic
	always_comb begin
		limit      = (frames_count_q > sfs_pkg::MAX_FRAMES) ? sfs_pkg::MAX_FRAMES
			: frames_count_q;
		cur_plus1  = {2'b00, frame_q} + 10'd1;
		fwd_frame  = sfs_pkg::show_frame(cur_plus1, limit);
		back_frame = (frame_q > 8'd1) ? sfs_pkg::show_frame({2'b00, frame_q - 8'd1}, limit)
			: '0;
		at_last    = (cur_plus1 == {1'b0, limit});
		rep_pos    = !repeats_q[sfs_pkg::REP_W-1] && (repeats_q != '0);
		acc_sat    = sfs_pkg::sat_add(acc_q, delta_s1);
		pause_sat  = sfs_pkg::sat_add(pause_q, delta_s1);
		range_next = {2'b00, range_start_q} + {2'b00, steps_q} + 10'd1;
	end

	// Sequencing logic for the request in the input stage
	always_comb begin
		n_frame      = frame_q;
		n_acc        = acc_q;
		n_delay      = delay_q;
		n_pause      = pause_q;
		n_repeats    = repeats_q;
		n_steps      = steps_q;
		n_running    = running_q;
		n_backward   = backward_q;
		n_range_mode = range_mode_q;
		cyc          = 1'b0;
		fin          = 1'b0;
		case (req_s1)
			sfs_pkg::REQ_TICK: begin
				if (!delay_q[sfs_pkg::DELAY_W-1]) begin
					// Count down the start delay
					n_delay = delay_q - $signed({2'b00, delta_s1});
				end else if (running_q && repeats_q != '0) begin
					n_acc = acc_sat;
					if (acc_sat >= {1'b0, frame_period_q}) begin
						n_acc = acc_sat - {1'b0, frame_period_q};
						if (ping_pong_q) begin
							// Bounce between frame 0 and the last frame
							if (backward_q) begin
								n_frame = back_frame;
								if (back_frame == '0)
									n_backward = 1'b0;
							end else begin
								n_frame = fwd_frame;
								if (({2'b00, fwd_frame} + 10'd1) >= {1'b0, limit})
									n_backward = 1'b1;
							end
						end else if (!range_mode_q) begin
							if (backward_q && frame_q == '0) begin
								// Reverse play reached the first frame
								n_running  = 1'b0;
								n_backward = 1'b0;
								fin        = 1'b1;
							end else begin
								if (rep_pos && at_last) begin
									n_repeats = repeats_q - 9'sd1;
									if (repeats_q == 9'sd1) begin
										n_running = 1'b0;
										fin       = 1'b1;
									end
								end
								n_frame = backward_q ? back_frame : fwd_frame;
								if (at_last) begin
									cyc = 1'b1;
									// Hold on the last frame for the cycle pause
									if (cycle_pause_q != '0) begin
										if (pause_sat < {1'b0, cycle_pause_q}) begin
											n_pause = pause_sat;
											n_frame = frame_q;
										end else begin
											n_pause = '0;
										end
									end
								end
							end
						end else begin
							// Range play
							if (frame_q < range_finish_q) begin
								n_frame = sfs_pkg::show_frame(range_next, limit);
								n_steps = steps_q + 8'd1;
							end else if (rep_pos) begin
								n_repeats = repeats_q - 9'sd1;
								n_steps   = '0;
								if (repeats_q == 9'sd1) begin
									n_running = 1'b0;
									fin       = 1'b1;
								end
							end else begin
								n_steps = '0;
								n_frame = sfs_pkg::show_frame({2'b00, range_start_q}, limit);
							end
						end
					end
				end
			end
			sfs_pkg::REQ_START_SHEET, sfs_pkg::REQ_START_RANGE: begin
				// Arm the animation
				n_acc        = '0;
				n_steps      = '0;
				n_running    = 1'b1;
				n_delay      = $signed({2'b00, start_delay_q});
				n_repeats    = (repeat_count_q == '0) ? sfs_pkg::REP_ENDLESS
					: $signed({1'b0, repeat_count_q});
				n_range_mode = (req_s1 == sfs_pkg::REQ_START_RANGE);
				if (req_s1 == sfs_pkg::REQ_START_RANGE)
					n_frame = sfs_pkg::show_frame({2'b00, range_start_q}, limit);
			end
			default: begin
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_count_q <= sfs_pkg::COUNT_W'(1);
			frame_period_q <= sfs_pkg::TIME_W'(1);
			start_delay_q  <= '0;
			cycle_pause_q  <= '0;
			repeat_count_q <= '0;
			ping_pong_q    <= 1'b0;
			range_start_q  <= '0;
			range_finish_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (sfs_pkg::cfg_index_t'(cfg_index))
				sfs_pkg::CFG_FRAMES_COUNT: frames_count_q <= cfg_data[sfs_pkg::COUNT_W-1:0];
				sfs_pkg::CFG_FRAME_PERIOD: frame_period_q <= cfg_data;
				sfs_pkg::CFG_START_DELAY:  start_delay_q  <= cfg_data;
				sfs_pkg::CFG_CYCLE_PAUSE:  cycle_pause_q  <= cfg_data;
				sfs_pkg::CFG_REPEAT_COUNT: repeat_count_q <= cfg_data[7:0];
				sfs_pkg::CFG_PING_PONG:    ping_pong_q    <= cfg_data[0];
				sfs_pkg::CFG_RANGE_START:  range_start_q  <= cfg_data[7:0];
				sfs_pkg::CFG_RANGE_FINISH: range_finish_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage: hold a request until the result register can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1   <= sfs_pkg::req_type_t'(s_tuser);
			delta_s1 <= s_tdata;
		end
	end

	// Apply the state update as the request moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q      <= '0;
			acc_q        <= '0;
			delay_q      <= '0;
			pause_q      <= '0;
			repeats_q    <= sfs_pkg::REP_ENDLESS;
			steps_q      <= '0;
			running_q    <= 1'b0;
			backward_q   <= 1'b0;
			range_mode_q <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (adv_s1) begin
				frame_q      <= n_frame;
				acc_q        <= n_acc;
				delay_q      <= n_delay;
				pause_q      <= n_pause;
				repeats_q    <= n_repeats;
				steps_q      <= n_steps;
				running_q    <= n_running;
				backward_q   <= n_backward;
				range_mode_q <= n_range_mode;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv_s1)
			data_s2 <= {5'b00000, fin, cyc, n_running, n_frame};
	end

endmodule
